/* hdl/rcbp_pkg.sv */
`default_nettype none

package rcbp_pkg;

   typedef enum logic [1:0] {
      OP_ALLOC         = 2'd0,
      OP_RELEASE       = 2'd1,
      OP_ADD_REF       = 2'd2,
      OP_MAKE_WRITABLE = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      STATUS_OK        = 2'd0,
      STATUS_EXHAUSTED = 2'd1,
      STATUS_BAD_INDEX = 2'd2,
      STATUS_SATURATED = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      FSM_INIT = 2'd0,
      FSM_IDLE = 2'd1,
      FSM_EXEC = 2'd2,
      FSM_COPY = 2'd3
   } fsm_type;

   localparam int OP_W        = 2;
   localparam int INDEX_W     = 6;
   localparam int COUNT_OUT_W = 8;
   localparam int USE_W       = 7;
   localparam int POOL_W      = 7;
   localparam int REQ_DATA_W  = 8;
   localparam int RSP_DATA_W  = 40;

   localparam logic [POOL_W-1:0] POOL_SIZE_RESET = 7'd64;

   typedef struct packed {
      logic [1:0]             pad;
      logic [USE_W-1:0]       buffers_in_use_max;
      logic [USE_W-1:0]       buffers_in_use;
      logic [COUNT_OUT_W-1:0] ref_count_now;
      logic                   buffer_freed;
      logic [INDEX_W-1:0]     copy_source;
      logic                   copy_needed;
      logic [INDEX_W-1:0]     result_index;
      status_type             status;
   } rsp_word_type;

endpackage

`default_nettype wire

/* hdl/rcbp_ram.sv */
`default_nettype none

module rcbp_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic                   clock,
   input  wire logic                   we,
   input  wire logic [AW-1:0]          waddr,
   input  wire logic [WIDTH-1:0]       wdata,
   input  wire logic                   re,
   input  wire logic [AW-1:0]          raddr,
   output logic      [WIDTH-1:0]       rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

`default_nettype wire

/* hdl/refcounted_block_pool.sv */
// An accepted word executes in FSM_EXEC; its result is registered as it leaves FSM_EXEC.
// The next word is accepted only back in FSM_IDLE; a make-writable copy first passes
// FSM_COPY, which writes back the shared buffer's count. The pacing follows the read and
// write-back of the count and free-stack memories. A word waits in FSM_EXEC while the
// previous result is not taken. Reset and every pool_size write rerun FSM_INIT over all
// NUM_BUFFERS entries to rebuild the free stack and clear all counts, accepting no word.
`default_nettype none

module refcounted_block_pool #(
   parameter int NUM_BUFFERS    = 64,
   parameter int REF_COUNT_BITS = 8
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   // block_index [5:0], zero [7:6]
   input  wire logic [7:0]  req_tdata,
   // op [1:0]
   input  wire logic [1:0]  req_tuser,
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   // status [1:0], result_index [7:2], copy_needed [8], copy_source [14:9],
   // buffer_freed [15], ref_count_now [23:16], buffers_in_use [30:24],
   // buffers_in_use_max [37:31], zero [39:38]
   output logic [39:0]      rsp_tdata,
   input  wire logic        csr_we,
   input  wire logic [6:0]  csr_wdata
);

   localparam int IDX_W = (NUM_BUFFERS > 1) ? $clog2(NUM_BUFFERS) : 1;
   localparam int TOP_W = $clog2(NUM_BUFFERS + 1);
   localparam int CNT_W = REF_COUNT_BITS;
   localparam logic [CNT_W-1:0] CNT_MAX  = '1;
   localparam logic [CNT_W-1:0] CNT_ONE  = CNT_W'(1);
   localparam logic [TOP_W-1:0] TOP_FULL = TOP_W'(NUM_BUFFERS);
   localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(NUM_BUFFERS - 1);

   rcbp_pkg::fsm_type              state_ff, state_in;
   logic [IDX_W-1:0]               clr_ff, clr_in;
   logic [rcbp_pkg::POOL_W-1:0]    pool_size_ff, pool_size_in;
   logic [TOP_W-1:0]               top_ff, top_in;
   logic [TOP_W-1:0]               used_ff, used_in;
   logic [TOP_W-1:0]               hm_ff, hm_in;
   rcbp_pkg::op_type               op_ff, op_in;
   logic [rcbp_pkg::INDEX_W-1:0]   bi_ff, bi_in;
   logic [CNT_W-1:0]               cnt_ff, cnt_in;
   logic                           rsp_valid_ff, rsp_valid_in;
   rcbp_pkg::rsp_word_type         rsp_word_ff, rsp_word_in;

   logic [TOP_W-1:0]               size_eff;
   logic [TOP_W-1:0]               used_inc;
   logic [TOP_W-1:0]               hm_inc;
   logic                           accept;
   logic                           hold;
   logic                           can_pop;
   logic                           bad;
   logic [IDX_W-1:0]               bi_addr;

   logic                           rc_we, rc_re;
   logic [IDX_W-1:0]               rc_waddr, rc_raddr;
   logic [CNT_W-1:0]               rc_wdata, rc_rdata;
   logic                           stk_we, stk_re;
   logic [IDX_W-1:0]               stk_waddr, stk_raddr;
   logic [IDX_W-1:0]               stk_wdata, stk_rdata;

   rcbp_pkg::status_type           status_v;
   logic [IDX_W-1:0]               res_v;
   logic                           cneed_v;
   logic                           freed_v;
   logic [CNT_W-1:0]               rcn_v;

   rcbp_ram #(.WIDTH(CNT_W), .DEPTH(NUM_BUFFERS)) u_count_ram (
      .clock (clock),
      .we    (rc_we),
      .waddr (rc_waddr),
      .wdata (rc_wdata),
      .re    (rc_re),
      .raddr (rc_raddr),
      .rdata (rc_rdata)
   );

   rcbp_ram #(.WIDTH(IDX_W), .DEPTH(NUM_BUFFERS)) u_stack_ram (
      .clock (clock),
      .we    (stk_we),
      .waddr (stk_waddr),
      .wdata (stk_wdata),
      .re    (stk_re),
      .raddr (stk_raddr),
      .rdata (stk_rdata)
   );

   assign size_eff = (32'(pool_size_ff) > NUM_BUFFERS) ? TOP_FULL : TOP_W'(pool_size_ff);
   assign req_tready = (state_ff == rcbp_pkg::FSM_IDLE);
   assign accept = req_tvalid && req_tready;
   assign hold = rsp_valid_ff && !rsp_tready;
   assign can_pop = (top_ff != '0);
   assign bi_addr = IDX_W'(bi_ff);
   assign bad = (bi_ff >= size_eff) || (rc_rdata == '0);
   assign used_inc = used_ff + 1'b1;
   assign hm_inc = (used_inc > hm_ff) ? used_inc : hm_ff;

   assign rc_re = accept;
   assign rc_raddr = IDX_W'(req_tdata[rcbp_pkg::INDEX_W-1:0]);
   assign stk_re = accept;
   assign stk_raddr = IDX_W'(top_ff - 1'b1);

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata = rsp_word_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= rcbp_pkg::FSM_INIT;
         clr_ff       <= '0;
         pool_size_ff <= rcbp_pkg::POOL_SIZE_RESET;
         top_ff       <= '0;
         used_ff      <= '0;
         hm_ff        <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         pool_size_ff <= pool_size_in;
         top_ff       <= top_in;
         used_ff      <= used_in;
         hm_ff        <= hm_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff       <= op_in;
      bi_ff       <= bi_in;
      cnt_ff      <= cnt_in;
      rsp_word_ff <= rsp_word_in;
   end

   always_comb begin
      state_in     = state_ff;
      clr_in       = clr_ff;
      pool_size_in = pool_size_ff;
      top_in       = top_ff;
      used_in      = used_ff;
      hm_in        = hm_ff;
      op_in        = op_ff;
      bi_in        = bi_ff;
      cnt_in       = cnt_ff;
      rsp_valid_in = hold;
      rsp_word_in  = rsp_word_ff;
      rc_we        = 1'b0;
      rc_waddr     = bi_addr;
      rc_wdata     = '0;
      stk_we       = 1'b0;
      stk_waddr    = IDX_W'(top_ff);
      stk_wdata    = bi_addr;
      status_v     = rcbp_pkg::STATUS_OK;
      res_v        = '0;
      cneed_v      = 1'b0;
      freed_v      = 1'b0;
      rcn_v        = '0;

      unique case (state_ff)
         rcbp_pkg::FSM_INIT: begin
            rc_we     = 1'b1;
            rc_waddr  = clr_ff;
            stk_we    = 1'b1;
            stk_waddr = clr_ff;
            stk_wdata = (clr_ff < size_eff) ?
                        IDX_W'(size_eff - TOP_W'(clr_ff) - 1'b1) : '0;
            top_in    = size_eff;
            used_in   = '0;
            hm_in     = '0;
            if (clr_ff == IDX_LAST) begin
               state_in = rcbp_pkg::FSM_IDLE;
            end else begin
               clr_in = clr_ff + 1'b1;
            end
         end
         rcbp_pkg::FSM_IDLE: begin
            if (accept) begin
               op_in    = rcbp_pkg::op_type'(req_tuser[rcbp_pkg::OP_W-1:0]);
               bi_in    = req_tdata[rcbp_pkg::INDEX_W-1:0];
               state_in = rcbp_pkg::FSM_EXEC;
            end
         end
         rcbp_pkg::FSM_EXEC: begin
            if (!hold) begin
               state_in = rcbp_pkg::FSM_IDLE;
               if (op_ff == rcbp_pkg::OP_ALLOC) begin
                  if (can_pop) begin
                     top_in   = top_ff - 1'b1;
                     rc_we    = 1'b1;
                     rc_waddr = stk_rdata;
                     rc_wdata = CNT_ONE;
                     used_in  = used_inc;
                     hm_in    = hm_inc;
                     res_v    = stk_rdata;
                     rcn_v    = CNT_ONE;
                  end else begin
                     status_v = rcbp_pkg::STATUS_EXHAUSTED;
                  end
               end else if (bad) begin
                  status_v = rcbp_pkg::STATUS_BAD_INDEX;
                  if (op_ff == rcbp_pkg::OP_MAKE_WRITABLE) begin
                     res_v = bi_addr;
                  end
               end else begin
                  unique case (op_ff)
                     rcbp_pkg::OP_RELEASE: begin
                        rc_we = 1'b1;
                        if (rc_rdata > CNT_ONE) begin
                           rc_wdata = rc_rdata - 1'b1;
                           rcn_v    = rc_rdata - 1'b1;
                        end else begin
                           freed_v = 1'b1;
                           if (top_ff < TOP_FULL) begin
                              stk_we = 1'b1;
                              top_in = top_ff + 1'b1;
                           end
                           if (used_ff != '0) begin
                              used_in = used_ff - 1'b1;
                           end
                        end
                     end
                     rcbp_pkg::OP_ADD_REF: begin
                        if (rc_rdata == CNT_MAX) begin
                           status_v = rcbp_pkg::STATUS_SATURATED;
                           rcn_v    = rc_rdata;
                        end else begin
                           rc_we    = 1'b1;
                           rc_wdata = rc_rdata + 1'b1;
                           rcn_v    = rc_rdata + 1'b1;
                        end
                     end
                     rcbp_pkg::OP_MAKE_WRITABLE: begin
                        res_v = bi_addr;
                        rcn_v = rc_rdata;
                        if (rc_rdata > CNT_ONE) begin
                           if (can_pop) begin
                              top_in   = top_ff - 1'b1;
                              rc_we    = 1'b1;
                              rc_waddr = stk_rdata;
                              rc_wdata = CNT_ONE;
                              used_in  = used_inc;
                              hm_in    = hm_inc;
                              res_v    = stk_rdata;
                              cneed_v  = 1'b1;
                              rcn_v    = rc_rdata - 1'b1;
                              cnt_in   = rc_rdata - 1'b1;
                              state_in = rcbp_pkg::FSM_COPY;
                           end else begin
                              status_v = rcbp_pkg::STATUS_EXHAUSTED;
                           end
                        end
                     end
                     default: begin
                     end
                  endcase
               end
               rsp_valid_in                   = 1'b1;
               rsp_word_in.pad                = '0;
               rsp_word_in.status             = status_v;
               rsp_word_in.result_index       = rcbp_pkg::INDEX_W'(res_v);
               rsp_word_in.copy_needed        = cneed_v;
               rsp_word_in.copy_source        = cneed_v ? bi_ff : '0;
               rsp_word_in.buffer_freed       = freed_v;
               rsp_word_in.ref_count_now      = rcbp_pkg::COUNT_OUT_W'(rcn_v);
               rsp_word_in.buffers_in_use     = rcbp_pkg::USE_W'(used_in);
               rsp_word_in.buffers_in_use_max = rcbp_pkg::USE_W'(hm_in);
            end
         end
         rcbp_pkg::FSM_COPY: begin
            rc_we    = 1'b1;
            rc_wdata = cnt_ff;
            state_in = rcbp_pkg::FSM_IDLE;
         end
         default: begin
            state_in = rcbp_pkg::FSM_INIT;
         end
      endcase

      if (csr_we) begin
         pool_size_in = csr_wdata;
         state_in     = rcbp_pkg::FSM_INIT;
         clr_in       = '0;
      end
   end

endmodule

`default_nettype wire
